// ===== design/rlc_pkg.sv =====
// Shared definitions for the reference-counted LRU object cache.
// Field widths, command codes, sequencer states and parameter defaults.
// No dependencies.
package rlc_pkg;

   // Port field widths
   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 32;
   localparam int TIME_W   = 32;
   localparam int SLOT_W   = 3;

   // Use count storage
   localparam int USES_W = 8;
   localparam logic [USES_W-1:0] USES_MAX  = 8'd255;
   localparam logic [USES_W-1:0] USES_ZERO = 8'd0;
   localparam logic [USES_W-1:0] USES_ONE  = 8'd1;

   // Command codes
   localparam logic CMD_LOOKUP  = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // Parameter defaults
   localparam int DEF_ENTRIES     = 8;
   localparam int DEF_KEY_BITS    = 32;
   localparam int DEF_HANDLE_BITS = 32;
   localparam int DEF_TIME_BITS   = 32;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== design/rlc_store.sv =====
// Entry store of the object cache: one synchronous memory with a write port and
// a separate registered read port, plus per-entry valid bits in flip-flops.
// Depends on rlc_pkg only through the top level's parameters.
module rlc_store #(
   parameter int ENTRIES = 8,
   parameter int EW      = 104
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [EW-1:0]              rd_data,
   output logic                       rd_valid,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [EW-1:0]              wr_data
);

   logic [EW-1:0]      mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [EW-1:0]      rd_raw_ff;
   logic               rd_valid_ff;

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   // Valid bits; an entry never written reads as all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_data  = rd_valid_ff ? rd_raw_ff : '0;

endmodule

// ===== design/refcounted_lru_object_cache.sv =====
// Reference-counted LRU object cache, fully associative, ENTRIES deep.
// The scan reads the memory one entry per cycle, and the result strobe is registered
// from the done state. Busy is high during the scan and the done state; start is taken
// only while idle, so a new item cannot begin before the last one is through.
// The receiver cannot stall, so a result never waits.
// Reset (synchronous, active high) clears all valid bits: every entry reads as empty.
module refcounted_lru_object_cache #(
   parameter int ENTRIES     = rlc_pkg::DEF_ENTRIES,
   parameter int KEY_BITS    = rlc_pkg::DEF_KEY_BITS,
   parameter int HANDLE_BITS = rlc_pkg::DEF_HANDLE_BITS,
   parameter int TIME_BITS   = rlc_pkg::DEF_TIME_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic [rlc_pkg::KEY_W-1:0]     req_key,
   input  logic [rlc_pkg::TIME_W-1:0]    req_now,
   input  logic                          req_fetch_ok,
   input  logic [rlc_pkg::HANDLE_W-1:0]  req_new_handle,
   input  logic                          req_holding,
   output logic                          rsp_strobe,
   output logic                          rsp_hit,
   output logic [rlc_pkg::HANDLE_W-1:0]  rsp_handle_out,
   output logic                          rsp_inserted,
   output logic [rlc_pkg::SLOT_W-1:0]    rsp_slot,
   output logic                          rsp_evict_valid,
   output logic [rlc_pkg::HANDLE_W-1:0]  rsp_evicted_handle,
   output logic                          rsp_free_now
);

   import rlc_pkg::*;

   localparam int IW    = $clog2(ENTRIES);
   localparam int CW    = $clog2(ENTRIES + 1);
   localparam int KW    = KEY_BITS;
   localparam int HW    = HANDLE_BITS;
   localparam int TW    = TIME_BITS;
   localparam int T_LSB = USES_W;
   localparam int H_LSB = USES_W + TW;
   localparam int K_LSB = USES_W + TW + HW;
   localparam int EW    = USES_W + TW + HW + KW;

   localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);
   localparam logic [CW-1:0] PTR_LIMIT = CW'(ENTRIES);

   state_type state_ff, state_in;

   // Latched request
   logic          cmd_ff;
   logic [KW-1:0] key_ff;
   logic [TW-1:0] now_ff;
   logic          fetch_ok_ff;
   logic [HW-1:0] nh_ff;
   logic          holding_ff;

   // Scan control
   logic [CW-1:0] ptr_ff;
   logic          rd_vld_ff;
   logic [IW-1:0] rd_tag_ff;
   logic          rd_en;
   logic          scan_end;

   // Store ports
   logic [EW-1:0] rd_data;
   logic          rd_valid;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   // Fields of the entry being read
   logic [KW-1:0]     rd_key;
   logic [HW-1:0]     rd_handle;
   logic [TW-1:0]     rd_time;
   logic [USES_W-1:0] rd_uses;
   logic              take_match;
   logic              take_victim;

   // Trackers: first matching entry and oldest unused entry
   logic              match_found_ff;
   logic [IW-1:0]     match_idx_ff;
   logic [HW-1:0]     match_handle_ff;
   logic [TW-1:0]     match_time_ff;
   logic [USES_W-1:0] match_uses_ff;
   logic              vic_found_ff;
   logic [IW-1:0]     vic_idx_ff;
   logic [HW-1:0]     vic_handle_ff;
   logic [TW-1:0]     vic_time_ff;
   logic              vic_valid_ff;

   // Result decision
   logic                is_lookup;
   logic                is_release;
   logic                res_hit;
   logic                res_miss_fetched;
   logic                res_inserted;
   logic                res_released;
   logic                res_evict;
   logic                res_free;
   logic [HANDLE_W-1:0] res_handle;
   logic [SLOT_W-1:0]   res_slot;
   logic [HANDLE_W-1:0] res_evicted;
   logic [USES_W-1:0]   uses_inc;
   logic [USES_W-1:0]   uses_dec;

   // Result registers
   logic                rsp_strobe_ff;
   logic                rsp_hit_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic                rsp_inserted_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_evict_ff;
   logic [HANDLE_W-1:0] rsp_evicted_ff;
   logic                rsp_free_ff;

   rlc_store #(
      .ENTRIES (ENTRIES),
      .EW      (EW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (ptr_ff[IW-1:0]),
      .rd_data  (rd_data),
      .rd_valid (rd_valid),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   // Unpack the entry returned by the store
   assign rd_uses   = rd_data[USES_W-1:0];
   assign rd_time   = rd_data[T_LSB +: TW];
   assign rd_handle = rd_data[H_LSB +: HW];
   assign rd_key    = rd_data[K_LSB +: KW];

   assign take_match  = rd_vld_ff && rd_valid && rd_key == key_ff && !match_found_ff;
   assign take_victim = rd_vld_ff && rd_uses == USES_ZERO &&
                        (!vic_found_ff || rd_time < vic_time_ff);
   assign scan_end    = rd_vld_ff && rd_tag_ff == LAST_IDX;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outcome of the item, from the finished scan
   always_comb begin
      is_lookup        = cmd_ff == CMD_LOOKUP;
      is_release       = cmd_ff == CMD_RELEASE;
      res_hit          = is_lookup && match_found_ff;
      res_miss_fetched = is_lookup && !match_found_ff && fetch_ok_ff;
      res_inserted     = res_miss_fetched && vic_found_ff;
      res_released     = is_release && holding_ff && match_found_ff;
      res_free         = is_release && holding_ff && !match_found_ff;
      res_evict        = res_inserted && vic_valid_ff;

      res_handle = '0;
      if (res_hit) begin
         res_handle = HANDLE_W'(match_handle_ff);
      end else if (res_miss_fetched) begin
         res_handle = HANDLE_W'(nh_ff);
      end

      res_slot = '0;
      if (res_hit || res_released) begin
         res_slot = SLOT_W'(match_idx_ff);
      end else if (res_inserted) begin
         res_slot = SLOT_W'(vic_idx_ff);
      end

      res_evicted = res_evict ? HANDLE_W'(vic_handle_ff) : '0;

      uses_inc = (match_uses_ff == USES_MAX) ? match_uses_ff : match_uses_ff + USES_ONE;
      uses_dec = (match_uses_ff == USES_ZERO) ? match_uses_ff : match_uses_ff - USES_ONE;
   end

   // Control outputs: memory read during the scan, write-back when done
   always_comb begin
      busy    = state_ff != ST_IDLE;
      rd_en   = state_ff == ST_SCAN && ptr_ff < PTR_LIMIT;
      wr_en   = 1'b0;
      wr_addr = match_idx_ff;
      wr_data = {key_ff, match_handle_ff, match_time_ff, uses_inc};
      if (state_ff == ST_DONE) begin
         if (res_hit) begin
            wr_en = 1'b1;
         end else if (res_inserted) begin
            wr_en   = 1'b1;
            wr_addr = vic_idx_ff;
            wr_data = {key_ff, nh_ff, vic_time_ff, USES_ONE};
         end else if (res_released) begin
            wr_en   = 1'b1;
            wr_data = {key_ff, match_handle_ff, now_ff, uses_dec};
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ptr_ff         <= '0;
         rd_vld_ff      <= 1'b0;
         match_found_ff <= 1'b0;
         vic_found_ff   <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_en;
         rsp_strobe_ff <= state_ff == ST_DONE;
         if (state_ff == ST_IDLE && start) begin
            ptr_ff         <= '0;
            match_found_ff <= 1'b0;
            vic_found_ff   <= 1'b0;
         end else begin
            if (rd_en) begin
               ptr_ff <= ptr_ff + CW'(1);
            end
            if (take_match) begin
               match_found_ff <= 1'b1;
            end
            if (take_victim) begin
               vic_found_ff <= 1'b1;
            end
         end
      end
   end

   // Request latch, scan trackers and result payload
   always_ff @(posedge clock) begin
      rd_tag_ff <= ptr_ff[IW-1:0];
      if (state_ff == ST_IDLE && start) begin
         cmd_ff      <= req_cmd;
         key_ff      <= KW'(req_key);
         now_ff      <= TW'(req_now);
         fetch_ok_ff <= req_fetch_ok;
         nh_ff       <= HW'(req_new_handle);
         holding_ff  <= req_holding;
      end
      if (take_match) begin
         match_idx_ff    <= rd_tag_ff;
         match_handle_ff <= rd_handle;
         match_time_ff   <= rd_time;
         match_uses_ff   <= rd_uses;
      end
      if (take_victim) begin
         vic_idx_ff    <= rd_tag_ff;
         vic_handle_ff <= rd_handle;
         vic_time_ff   <= rd_time;
         vic_valid_ff  <= rd_valid;
      end
      if (state_ff == ST_DONE) begin
         rsp_hit_ff      <= res_hit;
         rsp_handle_ff   <= res_handle;
         rsp_inserted_ff <= res_inserted;
         rsp_slot_ff     <= res_slot;
         rsp_evict_ff    <= res_evict;
         rsp_evicted_ff  <= res_evicted;
         rsp_free_ff     <= res_free;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_handle_out     = rsp_handle_ff;
   assign rsp_inserted       = rsp_inserted_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_evict_valid    = rsp_evict_ff;
   assign rsp_evicted_handle = rsp_evicted_ff;
   assign rsp_free_now       = rsp_free_ff;

endmodule

// ===== test/refcounted_lru_object_cache_tb.sv =====
// Self-checking testbench for refcounted_lru_object_cache: directed and random commands
// checked against a cycle-free mirror of the cache contents and reference counts.
// Depends on rlc_pkg and the refcounted_lru_object_cache RTL.
module refcounted_lru_object_cache_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rlc_pkg::*;

   localparam int ENTRIES    = DEF_ENTRIES;
   localparam int CYCLE_CAP  = 200000;
   localparam int TAIL_ITEMS = 120;
   localparam int FILL_RUNS  = 280;
   localparam int HAMMER_HITS = 258;
   localparam int HAMMER_RELS = 255;

   typedef struct {
      logic                cmd;
      logic [KEY_W-1:0]    key;
      logic [TIME_W-1:0]   now;
      logic                fetch_ok;
      logic [HANDLE_W-1:0] new_handle;
      logic                holding;
   } cache_cmd_type;

   typedef struct {
      logic                hit;
      logic [HANDLE_W-1:0] handle_out;
      logic                inserted;
      logic [SLOT_W-1:0]   slot;
      logic                evict_valid;
      logic [HANDLE_W-1:0] evicted_handle;
      logic                free_now;
   } cache_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic                req_cmd        = CMD_LOOKUP;
   logic [KEY_W-1:0]    req_key        = '0;
   logic [TIME_W-1:0]   req_now        = '0;
   logic                req_fetch_ok   = 1'b0;
   logic [HANDLE_W-1:0] req_new_handle = '0;
   logic                req_holding    = 1'b0;
   logic                rsp_strobe;
   logic                rsp_hit;
   logic [HANDLE_W-1:0] rsp_handle_out;
   logic                rsp_inserted;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                rsp_evict_valid;
   logic [HANDLE_W-1:0] rsp_evicted_handle;
   logic                rsp_free_now;

   // Mirror of the cache contents
   logic [KEY_W-1:0]    mir_key    [ENTRIES];
   logic [HANDLE_W-1:0] mir_handle [ENTRIES];
   logic [TIME_W-1:0]   mir_time   [ENTRIES];
   logic [USES_W-1:0]   mir_uses   [ENTRIES];
   logic                mir_valid  [ENTRIES];

   cache_cmd_type cmd_queue[$];
   cache_rsp_type rsp_due[$];
   cache_cmd_type on_port;
   int idle_left = 0;
   int idle_pct  = 0;
   int n_taken   = 0;
   int n_errors  = 0;
   int n_cycles  = 0;

   // Generator state
   logic [KEY_W-1:0]  key_pool[16];
   logic [KEY_W-1:0]  held_keys[$];
   logic [TIME_W-1:0] tick;

   refcounted_lru_object_cache dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_key           (req_key),
      .req_now           (req_now),
      .req_fetch_ok      (req_fetch_ok),
      .req_new_handle    (req_new_handle),
      .req_holding       (req_holding),
      .rsp_strobe        (rsp_strobe),
      .rsp_hit           (rsp_hit),
      .rsp_handle_out    (rsp_handle_out),
      .rsp_inserted      (rsp_inserted),
      .rsp_slot          (rsp_slot),
      .rsp_evict_valid   (rsp_evict_valid),
      .rsp_evicted_handle(rsp_evicted_handle),
      .rsp_free_now      (rsp_free_now)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Apply one command to the mirror and return the result it should produce
   function automatic cache_rsp_type predict_cache_rsp(cache_cmd_type c);
      cache_rsp_type r;
      int i, m, v;
      r = '{default: '0};
      m = -1;
      v = -1;
      for (i = 0; i < ENTRIES; i++)
         if (m < 0 && mir_valid[i] && mir_key[i] == c.key) m = i;
      if (c.cmd == CMD_LOOKUP) begin
         if (m >= 0) begin
            r.hit        = 1'b1;
            r.handle_out = mir_handle[m];
            r.slot       = m[SLOT_W-1:0];
            if (mir_uses[m] != USES_MAX) mir_uses[m] = mir_uses[m] + USES_ONE;
         end else if (c.fetch_ok) begin
            r.handle_out = c.new_handle;
            // oldest release among unused entries, lowest slot on a tie
            for (i = 0; i < ENTRIES; i++)
               if (mir_uses[i] == USES_ZERO && (v < 0 || mir_time[i] < mir_time[v])) v = i;
            if (v >= 0) begin
               r.inserted = 1'b1;
               r.slot     = v[SLOT_W-1:0];
               if (mir_valid[v]) begin
                  r.evict_valid    = 1'b1;
                  r.evicted_handle = mir_handle[v];
               end
               mir_key[v]    = c.key;
               mir_handle[v] = c.new_handle;
               mir_uses[v]   = USES_ONE;
               mir_valid[v]  = 1'b1;
            end
         end
      end else if (c.holding) begin
         if (m >= 0) begin
            r.slot = m[SLOT_W-1:0];
            if (mir_uses[m] != USES_ZERO) mir_uses[m] = mir_uses[m] - USES_ONE;
            mir_time[m] = c.now;
         end else begin
            r.free_now = 1'b1;
         end
      end
      return r;
   endfunction

   task automatic add_cmd(input logic cmd, input logic [KEY_W-1:0] key,
                          input logic [TIME_W-1:0] now, input logic fetch_ok,
                          input logic [HANDLE_W-1:0] new_handle, input logic holding);
      cache_cmd_type c;
      c.cmd        = cmd;
      c.key        = key;
      c.now        = now;
      c.fetch_ok   = fetch_ok;
      c.new_handle = new_handle;
      c.holding    = holding;
      cmd_queue.push_back(c);
   endtask

   // Mostly lookups paired with later releases of the same key, some noise
   task automatic add_random_cmd();
      int pick, idx;
      logic [KEY_W-1:0] k;
      logic ok;
      pick = $urandom_range(0, 99);
      tick = tick + $urandom_range(0, 40);
      if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(0, 15)] = $urandom;
      if (held_keys.size() > 12 && pick < 45) pick = 60;
      if (pick < 45) begin
         k  = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
         ok = ($urandom_range(0, 9) != 0);
         if (ok) held_keys.push_back(k);
         add_cmd(CMD_LOOKUP, k, $urandom, ok, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 80 && held_keys.size() > 0) begin
         idx = $urandom_range(0, held_keys.size() - 1);
         k = held_keys[idx];
         held_keys.delete(idx);
         add_cmd(CMD_RELEASE, k, ($urandom_range(0, 9) == 0) ? $urandom : tick,
                 1'($urandom_range(0, 1)), $urandom, ($urandom_range(0, 19) != 0));
      end else begin
         k = ($urandom_range(0, 1) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
         add_cmd(1'($urandom_range(0, 1)), k, $urandom, 1'($urandom_range(0, 1)),
                 $urandom, 1'($urandom_range(0, 1)));
      end
   endtask

   // Command list, then release reset, then wait for the last result
   initial begin
      logic [KEY_W-1:0] hot_key;
      int i;
      for (i = 0; i < ENTRIES; i++) begin
         mir_key[i]    = '0;
         mir_handle[i] = '0;
         mir_time[i]   = '0;
         mir_uses[i]   = USES_ZERO;
         mir_valid[i]  = 1'b0;
      end
      for (i = 0; i < 16; i++) key_pool[i] = $urandom;
      tick = $urandom_range(0, 1000);

      // failed fetch, then zero key and zero handle on an empty cache
      add_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0, 1'b0, 32'hFFFF_FFFF, 1'b0);
      add_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0, 1'b1, 32'h0000_0000, 1'b0);
      add_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
      add_cmd(CMD_LOOKUP, 32'h1234_5678, 32'h0, 1'b1, 32'h1111_1111, 1'b0);
      add_cmd(CMD_LOOKUP, 32'hA5A5_A5A5, 32'h0, 1'b1, 32'h2222_2222, 1'b0);
      add_cmd(CMD_LOOKUP, 32'h5A5A_5A5A, 32'h0, 1'b1, 32'h3333_3333, 1'b0);
      add_cmd(CMD_LOOKUP, 32'h0000_0001, 32'h0, 1'b1, 32'h4444_4444, 1'b0);
      add_cmd(CMD_LOOKUP, 32'h8000_0000, 32'h0, 1'b1, 32'h5555_5555, 1'b0);
      add_cmd(CMD_LOOKUP, 32'hDEAD_BEEF, 32'h0, 1'b1, 32'h6666_6666, 1'b0);
      // every entry in use: handle returned, not cached
      add_cmd(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0, 1'b1, 32'h7777_7777, 1'b0);
      add_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0);
      // release without holding, release of an unknown key
      add_cmd(CMD_RELEASE, 32'h0000_0000, 32'h123, 1'b1, 32'h1, 1'b0);
      add_cmd(CMD_RELEASE, 32'h7FFF_FFFF, 32'h9, 1'b0, 32'hAAAA_AAAA, 1'b1);
      add_cmd(CMD_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1);
      add_cmd(CMD_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1);
      add_cmd(CMD_RELEASE, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0, 1'b1);
      // release at zero count still stamps the time
      add_cmd(CMD_RELEASE, 32'h0000_0000, 32'h5, 1'b0, 32'h0, 1'b1);
      // victim is the older stamp, displacing a valid entry with handle zero
      add_cmd(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0, 1'b1, 32'h8888_8888, 1'b0);
      // equal stamps: the lower slot is chosen
      add_cmd(CMD_RELEASE, 32'hA5A5_A5A5, 32'h7, 1'b0, 32'h0, 1'b1);
      add_cmd(CMD_RELEASE, 32'h1234_5678, 32'h7, 1'b0, 32'h0, 1'b1);
      add_cmd(CMD_LOOKUP, 32'h3C3C_3C3C, 32'h0, 1'b1, 32'h9999_9999, 1'b0);
      add_cmd(CMD_LOOKUP, 32'h3C3C_3C3C, 32'h0, 1'b0, 32'h0, 1'b0);
      add_cmd(CMD_RELEASE, 32'h0000_0000, 32'h0, 1'b1, 32'h0, 1'b1);

      for (i = 0; i < FILL_RUNS; i++) add_random_cmd();

      // saturate one use count, then bring it back to zero and make it the victim
      while (held_keys.size() > 0)
         add_cmd(CMD_RELEASE, held_keys.pop_front(), tick, 1'b0, $urandom, 1'b1);
      hot_key = $urandom;
      for (i = 0; i < HAMMER_HITS; i++)
         add_cmd(CMD_LOOKUP, hot_key, $urandom, 1'b1, $urandom, 1'($urandom_range(0, 1)));
      for (i = 0; i < HAMMER_RELS; i++)
         add_cmd(CMD_RELEASE, hot_key, 32'h0, 1'($urandom_range(0, 1)), $urandom, 1'b1);
      add_cmd(CMD_LOOKUP, $urandom, tick, 1'b1, $urandom, 1'b0);

      for (i = 0; i < FILL_RUNS; i++) add_random_cmd();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() > 0 || start || rsp_due.size() > 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
      if (n_errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Driver: hand over the next item once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) begin
            rsp_due.push_back(predict_cache_rsp(on_port));
            n_taken++;
            if (n_taken % 50 == 0) begin
               case ($urandom_range(0, 2))
                  0: idle_pct = 0;
                  1: idle_pct = 20;
                  default: idle_pct = 50;
               endcase
            end
            if (cmd_queue.size() > TAIL_ITEMS && $urandom_range(0, 99) < idle_pct)
               idle_left = $urandom_range(1, 14);
         end
         if (idle_left > 0 || cmd_queue.size() == 0) begin
            // idle: junk on the request ports
            if (idle_left > 0) idle_left--;
            start          <= 1'b0;
            req_cmd        <= 1'($urandom_range(0, 1));
            req_key        <= $urandom;
            req_now        <= $urandom;
            req_fetch_ok   <= 1'($urandom_range(0, 1));
            req_new_handle <= $urandom;
            req_holding    <= 1'($urandom_range(0, 1));
         end else begin
            on_port = cmd_queue.pop_front();
            start          <= 1'b1;
            req_cmd        <= on_port.cmd;
            req_key        <= on_port.key;
            req_now        <= on_port.now;
            req_fetch_ok   <= on_port.fetch_ok;
            req_new_handle <= on_port.new_handle;
            req_holding    <= on_port.holding;
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
         n_errors++;
      end
   endtask

   // Monitor: each strobe is matched against the oldest outstanding item
   always @(posedge clock) begin
      cache_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (rsp_due.size() == 0) begin
            $error("result strobe with no item outstanding");
            n_errors++;
         end else begin
            want = rsp_due.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_hit));
            check_field("handle_out", want.handle_out, rsp_handle_out);
            check_field("inserted", 32'(want.inserted), 32'(rsp_inserted));
            check_field("slot", 32'(want.slot), 32'(rsp_slot));
            check_field("evict_valid", 32'(want.evict_valid), 32'(rsp_evict_valid));
            check_field("evicted_handle", want.evicted_handle, rsp_evicted_handle);
            check_field("free_now", 32'(want.free_now), 32'(rsp_free_now));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles >= CYCLE_CAP) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
design/rlc_pkg.sv
design/rlc_store.sv
design/refcounted_lru_object_cache.sv
test/refcounted_lru_object_cache_tb.sv
